[rtl/core/swmm_pkg.sv]
// Shared types and constants for the sliding window min/max normalizer.
package swmm_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG_MODE         = 2'd2;

	// Fixed field widths.
	localparam int LEN_W     = 7;
	localparam int POS_W     = 6;
	localparam int NORM_W    = 16;
	localparam int FRAC_BITS = 15;

	// Reset value of the window length register.
	localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

	// Q1.15 saturation limits, as quotient magnitudes.
	localparam int Q_POS_LIMIT = 32767;
	localparam int Q_NEG_LIMIT = 32768;
	localparam logic [NORM_W-1:0] Q_ONE     = 16'h7FFF;
	localparam logic [NORM_W-1:0] Q_NEG_ONE = 16'h8000;

	// Results that bypass the divider.
	typedef enum logic [1:0] {
		SPEC_NONE,
		SPEC_ZERO,
		SPEC_FULL
	} spec_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CLEAR,
		ST_DROP,
		ST_SCAN_RD,
		ST_SCAN_ACC,
		ST_SCAN_END,
		ST_WIDEN,
		ST_DECIDE,
		ST_RE_RD,
		ST_PREP1,
		ST_PREP2,
		ST_DIV,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear_win;
		logic rd;
		logic drop;
		logic pos_clr;
		logic pos_inc;
		logic scan_init;
		logic scan_acc;
		logic scan_end;
		logic widen;
		logic prep1;
		logic prep2;
		logic div_start;
		logic emit;
		logic use_mem;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mode;
		logic re_any;
		logic changed;
		logic norm_en;
		logic pos_last;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

[rtl/core/swmm_div.sv]
// Restoring divider that forms a rounded Q1.15 quotient magnitude, one bit per cycle.
module swmm_div import swmm_pkg::*; #(
	parameter int NW = 17
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NW-1:0]             mag,
	input  logic [NW-1:0]             den,
	output logic                      done,
	output logic [NW+FRAC_BITS:0]     quot
);

	localparam int DW = NW + FRAC_BITS + 1;
	localparam int CW = $clog2(DW);

	logic [DW-1:0] dvd_q;
	logic [NW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW:0]   trial;
	logic [NW:0]   diff;
	logic          ge;

	// One trial subtraction per cycle; den is held steady by the datapath.
	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		diff  = trial - {1'b0, den};
		ge    = trial >= {1'b0, den};
	end

	// Busy and done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Dividend is scaled by 2^15 and offset by half the divisor for rounding.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DW'({mag, {FRAC_BITS{1'b0}}}) + DW'(den >> 1);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;

endmodule

[rtl/core/swmm_dp.sv]
// Datapath: window memory, extremes, scaling setup, divider and output register.
module swmm_dp import swmm_pkg::*; #(
	parameter int WINDOW_DEPTH = 64,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output sts_t                          sts,
	input  logic                          mode,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          sample_valid,
	input  logic                          cfg_fire,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [LEN_W-1:0]              cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          kind,
	output logic [POS_W-1:0]              position,
	output logic signed [NORM_W-1:0]      normalized,
	output logic                          norm_valid,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic                          extremes_valid,
	output logic [LEN_W-1:0]              filled_count,
	output logic                          last
);

	localparam int SB  = SAMPLE_BITS;
	localparam int AW  = $clog2(WINDOW_DEPTH);
	localparam int AW1 = AW + 1;
	localparam int NW  = SB + 1;
	localparam int DW  = NW + FRAC_BITS + 1;

	// Configuration registers.
	logic [LEN_W-1:0] wl_q;
	logic             norm_en_q;
	logic             log_q;

	// Latched input item and extremes at its start.
	logic                 mode_q;
	logic signed [SB-1:0] sample_q;
	logic                 vok_q;
	logic signed [SB-1:0] old_min_q;
	logic signed [SB-1:0] old_max_q;
	logic                 old_ok_q;

	// Window state.
	logic [SB:0]          mem [WINDOW_DEPTH];
	logic [SB:0]          rd_q;
	logic [AW-1:0]        head_q;
	logic [LEN_W-1:0]     cnt_q;
	logic [LEN_W-1:0]     run_q;
	logic [LEN_W-1:0]     pos_q;
	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic                 ext_ok_q;
	logic                 re_min_q;
	logic                 re_max_q;
	logic signed [SB-1:0] lo_q;
	logic signed [SB-1:0] hi_q;
	logic                 any_q;

	// Scaling setup.
	logic signed [NW-1:0] num_q;
	logic [NW-1:0]        den_q;
	logic                 nv_q;
	spec_t                spec_q;
	logic                 neg_q;
	logic [NW-1:0]        mag_q;

	// Output register.
	logic                      out_valid_q;
	logic                      kind_q;
	logic [POS_W-1:0]          position_q;
	logic signed [NORM_W-1:0]  normalized_q;
	logic                      norm_valid_q;
	logic signed [SB-1:0]      out_min_q;
	logic signed [SB-1:0]      out_max_q;
	logic                      out_ext_q;
	logic [LEN_W-1:0]          out_filled_q;
	logic                      last_q;

	// Combinational helpers.
	logic [LEN_W-1:0]     len;
	logic [LEN_W-1:0]     len_m1;
	logic [AW-1:0]        pos_a;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        head_nx;
	logic                 dok;
	logic signed [SB-1:0] dv;
	logic                 re_min_c;
	logic                 re_max_c;
	logic                 ent_ok;
	logic signed [SB-1:0] ent_v;
	logic signed [SB-1:0] e_v;
	logic                 e_ok;
	logic signed [NW-1:0] amin;
	logic signed [NW-1:0] amax;
	logic signed [NW-1:0] num_c;
	logic [NW-1:0]        den_c;
	spec_t                spec_c;
	logic                 div_done;
	logic [DW-1:0]        quot;
	logic [NORM_W-1:0]    sat_v;
	logic [NORM_W-1:0]    norm_c;
	logic                 out_free;

	// Effective window length, limited to 1..WINDOW_DEPTH.
	always_comb begin
		if (wl_q == '0) begin
			len = LEN_W'(1);
		end else if (int'(wl_q) > WINDOW_DEPTH) begin
			len = LEN_W'(WINDOW_DEPTH);
		end else begin
			len = wl_q;
		end
		len_m1 = len - 1'b1;
	end

	// Ring addressing: position 0 is the newest entry at head.
	always_comb begin
		pos_a = AW'(pos_q);
		if (head_q >= pos_a) begin
			rd_addr = head_q - pos_a;
		end else begin
			rd_addr = AW'(AW1'(head_q) + AW1'(WINDOW_DEPTH) - AW1'(pos_a));
		end
		head_nx = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
	end

	// Window memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.drop) begin
			mem[head_nx] <= {vok_q, vok_q ? sample_q : {SB{1'b0}}};
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Dropped entry and scanned entry decode.
	always_comb begin
		dv       = rd_q[SB-1:0];
		dok      = (len_m1 < cnt_q) && rd_q[SB];
		re_min_c = dok && ext_ok_q && (dv <= min_q);
		re_max_c = dok && ext_ok_q && (dv >= max_q);
		ent_v    = rd_q[SB-1:0];
		ent_ok   = (pos_q < cnt_q) && rd_q[SB];
	end

	// Scaling setup: numerator, divisor and the cases that skip the divider.
	always_comb begin
		e_v  = cmd.use_mem ? ent_v : sample_q;
		e_ok = cmd.use_mem ? ent_ok : vok_q;
		amin = min_q[SB-1] ? -{min_q[SB-1], min_q} : {min_q[SB-1], min_q};
		amax = max_q[SB-1] ? -{max_q[SB-1], max_q} : {max_q[SB-1], max_q};
		if (log_q) begin
			num_c  = {e_v[SB-1], e_v};
			den_c  = (amin > amax) ? amin : amax;
			spec_c = (min_q == '0 && max_q == '0) ? SPEC_ZERO : SPEC_NONE;
		end else begin
			num_c = {e_v[SB-1], e_v} - {min_q[SB-1], min_q};
			den_c = {max_q[SB-1], max_q} - {min_q[SB-1], min_q};
			if (max_q == min_q) begin
				spec_c = (max_q == '0) ? SPEC_ZERO : SPEC_FULL;
			end else begin
				spec_c = SPEC_NONE;
			end
		end
	end

	swmm_div #(
		.NW (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.mag    (mag_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	// Sign, saturation and special cases of the normalized value.
	always_comb begin
		if (neg_q) begin
			sat_v = (quot > DW'(Q_NEG_LIMIT)) ? Q_NEG_ONE : -quot[NORM_W-1:0];
		end else begin
			sat_v = (quot > DW'(Q_POS_LIMIT)) ? Q_ONE : quot[NORM_W-1:0];
		end
		if (!nv_q) begin
			norm_c = '0;
		end else begin
			case (spec_q)
				SPEC_ZERO: norm_c = '0;
				SPEC_FULL: norm_c = Q_ONE;
				default:   norm_c = sat_v;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Control state: configuration, window bookkeeping and extremes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q      <= LEN_RESET;
			norm_en_q <= 1'b0;
			log_q     <= 1'b0;
			head_q    <= '0;
			cnt_q     <= '0;
			run_q     <= '0;
			pos_q     <= '0;
			min_q     <= '0;
			max_q     <= '0;
			ext_ok_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					CFG_WINDOW_LENGTH: begin
						wl_q     <= cfg_data;
						cnt_q    <= '0;
						run_q    <= '0;
						min_q    <= '0;
						max_q    <= '0;
						ext_ok_q <= 1'b0;
					end
					CFG_NORMALIZE_ENABLE: norm_en_q <= cfg_data[0];
					CFG_LOG_MODE:         log_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				pos_q <= len_m1;
			end
			if (cmd.clear_win) begin
				cnt_q    <= '0;
				run_q    <= '0;
				min_q    <= '0;
				max_q    <= '0;
				ext_ok_q <= 1'b0;
			end
			if (cmd.drop) begin
				head_q <= head_nx;
				if (cnt_q < len) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (!vok_q) begin
					run_q <= '0;
				end else if (run_q < len) begin
					run_q <= run_q + 1'b1;
				end
			end
			if (cmd.pos_clr) begin
				pos_q <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + 1'b1;
			end
			// Rescan result replaces only the extremes that left the window, or clears them when no valid entry remains.
			if (cmd.scan_end) begin
				if (!any_q) begin
					ext_ok_q <= 1'b0;
					min_q    <= '0;
					max_q    <= '0;
				end else begin
					if (re_min_q) begin
						min_q <= lo_q;
					end
					if (re_max_q) begin
						max_q <= hi_q;
					end
				end
			end
			// A valid new sample widens the extremes.
			if (cmd.widen && vok_q) begin
				if (!ext_ok_q || sample_q < min_q) begin
					min_q <= sample_q;
				end
				if (!ext_ok_q || sample_q > max_q) begin
					max_q <= sample_q;
				end
				ext_ok_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= mode;
			sample_q  <= sample;
			vok_q     <= sample_valid;
			old_min_q <= min_q;
			old_max_q <= max_q;
			old_ok_q  <= ext_ok_q;
		end
		if (cmd.clear_win) begin
			vok_q <= 1'b0;
		end
		if (cmd.drop) begin
			re_min_q <= re_min_c;
			re_max_q <= re_max_c;
		end
		if (cmd.scan_init) begin
			any_q <= 1'b0;
		end else if (cmd.scan_acc && ent_ok) begin
			if (!any_q || ent_v < lo_q) begin
				lo_q <= ent_v;
			end
			if (!any_q || ent_v > hi_q) begin
				hi_q <= ent_v;
			end
			any_q <= 1'b1;
		end
		if (cmd.prep1) begin
			num_q  <= num_c;
			den_q  <= den_c;
			spec_q <= spec_c;
			nv_q   <= norm_en_q && ext_ok_q && e_ok;
		end
		if (cmd.prep2) begin
			neg_q <= num_q[NW-1];
			mag_q <= num_q[NW-1] ? -num_q : num_q;
		end
		// The whole result is held here, so the next transaction may run meanwhile.
		if (cmd.emit) begin
			kind_q       <= cmd.use_mem;
			position_q   <= cmd.use_mem ? POS_W'(pos_q) : '0;
			normalized_q <= norm_c;
			norm_valid_q <= nv_q;
			out_min_q    <= min_q;
			out_max_q    <= max_q;
			out_ext_q    <= ext_ok_q;
			out_filled_q <= run_q;
			last_q       <= cmd.use_mem ? (pos_q == len_m1) : 1'b1;
		end
	end

	// Status to the controller.
	always_comb begin
		sts.mode     = mode_q;
		sts.re_any   = re_min_c || re_max_c;
		sts.changed  = (ext_ok_q != old_ok_q) ||
			(ext_ok_q && (min_q != old_min_q || max_q != old_max_q));
		sts.norm_en  = norm_en_q;
		sts.pos_last = pos_q == len_m1;
		sts.div_done = div_done;
		sts.out_free = out_free;
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign position       = position_q;
	assign normalized     = normalized_q;
	assign norm_valid     = norm_valid_q;
	assign window_min     = out_min_q;
	assign window_max     = out_max_q;
	assign extremes_valid = out_ext_q;
	assign filled_count   = out_filled_q;
	assign last           = last_q;

endmodule

[rtl/core/swmm_ctrl.sv]
// Controller state machine that sequences one input transaction through the datapath.
module swmm_ctrl import swmm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   re_q;
	logic   re_d;

	// State register and re-emit flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			re_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			re_q    <= re_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		re_d        = re_q;
		cmd         = '0;
		cmd.use_mem = re_q;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				// Read the entry that drops out; harmless for a clear.
				cmd.rd  = 1'b1;
				re_d    = 1'b0;
				state_d = sts.mode ? ST_CLEAR : ST_DROP;
			end
			ST_CLEAR: begin
				cmd.clear_win = 1'b1;
				state_d       = ST_PREP1;
			end
			ST_DROP: begin
				cmd.drop = 1'b1;
				if (sts.re_any) begin
					cmd.pos_clr   = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN_RD;
				end else begin
					state_d = ST_WIDEN;
				end
			end
			ST_SCAN_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_SCAN_ACC;
			end
			ST_SCAN_ACC: begin
				cmd.scan_acc = 1'b1;
				if (sts.pos_last) begin
					state_d = ST_SCAN_END;
				end else begin
					cmd.pos_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_SCAN_END: begin
				cmd.scan_end = 1'b1;
				state_d      = ST_WIDEN;
			end
			ST_WIDEN: begin
				cmd.widen = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.changed && sts.norm_en) begin
					re_d        = 1'b1;
					cmd.pos_clr = 1'b1;
					state_d     = ST_RE_RD;
				end else begin
					state_d = ST_PREP1;
				end
			end
			ST_RE_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_PREP1;
			end
			ST_PREP1: begin
				cmd.prep1 = 1'b1;
				state_d   = ST_PREP2;
			end
			ST_PREP2: begin
				cmd.prep2 = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (re_q && !sts.pos_last) begin
						cmd.pos_inc = 1'b1;
						state_d     = ST_RE_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/sliding_window_min_max_normalizer.sv]
// Top level of the sliding window min/max normalizer.
//
// Input channel (in_valid/in_ready) takes one transaction at a time: mode 0
// pushes sample/sample_valid into the window, mode 1 invalidates the window.
// Output channel (out_valid/out_ready) returns one result, or window-length
// results of kind 1 when the extremes changed with normalizing enabled; the
// final one carries last. Configuration writes (cfg_valid/cfg_ready) are
// always taken and must arrive while the block is idle; writing the window
// length also invalidates the window.
// A push with one result is paced mostly by the bit-serial divider. A rescan
// of the extremes reads the window memory through its single read port, one
// entry at a time. A re-emit runs the divider once for each window entry.
// in_ready is high only between transactions.
// The last result waits in the output register while the next transaction
// starts; a stalled receiver holds the block at its next result.
// After reset the window is empty, extremes are zero and invalid, window
// length is 64 and normalizing is off; no clearing pass is needed.
module sliding_window_min_max_normalizer import swmm_pkg::*; #(
	parameter int WINDOW_DEPTH = 64,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          sample_valid,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [LEN_W-1:0]              cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [POS_W-1:0]              position,
	output logic signed [NORM_W-1:0]      normalized,
	output logic                          norm_valid,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic                          extremes_valid,
	output logic [LEN_W-1:0]              filled_count,
	output logic                          last
);

	cmd_t cmd;
	sts_t sts;
	logic cfg_fire;

	// Configuration writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	swmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swmm_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.sample         (sample),
		.sample_valid   (sample_valid),
		.cfg_fire       (cfg_fire),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.kind           (kind),
		.position       (position),
		.normalized     (normalized),
		.norm_valid     (norm_valid),
		.window_min     (window_min),
		.window_max     (window_max),
		.extremes_valid (extremes_valid),
		.filled_count   (filled_count),
		.last           (last)
	);

endmodule
